### rtl/lpa_pkg.sv
// lpa_pkg: shared types, codes and constants for the lease pool allocator
// used by lpa_cell and lease_pool_allocator; depends on nothing else
`default_nettype none

package lpa_pkg;

    // field widths fixed by the request and result formats
    localparam int unsigned MAC_W      = 48;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned HOST_W     = 8;
    localparam int unsigned OUTCOME_W  = 2;
    localparam int unsigned LEASE_W    = 24;
    localparam int unsigned IN_TDATA_W = 80;
    localparam int unsigned OUT_TDATA_W = 16;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 24;

    // pool sizing; the entry index shares the host number width (pool is at most 256)
    localparam int unsigned POOL_SIZE_DEF = 64;
    localparam int unsigned IDX_W         = 8;

    // register reset values
    localparam logic [HOST_W-1:0]  POOL_START_RST = 8'd100;
    localparam logic [LEASE_W-1:0] LEASE_TIME_RST = 24'd36000;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POOL_START = 1'b0,
        REG_LEASE_TIME = 1'b1
    } lpa_reg_t;

    // result codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_REUSED    = 2'd0,
        OUT_CLAIMED   = 2'd1,
        OUT_EXHAUSTED = 2'd2
    } lpa_outcome_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } lpa_state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } lpa_carry_t;

    // entry update broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] expiry;
    } lpa_write_t;

endpackage : lpa_pkg

`default_nettype wire

### rtl/lpa_cell.sv
// lpa_cell: one lease entry (address and expiry) plus one stage of the search chain
// depends on lpa_pkg
`default_nettype none

module lpa_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lpa_pkg::MAC_W-1:0]  req_mac,
    input  wire logic [lpa_pkg::TIME_W-1:0] req_now,
    input  wire lpa_pkg::lpa_write_t        wr,
    input  wire lpa_pkg::lpa_carry_t        carry_in,
    output lpa_pkg::lpa_carry_t             carry_out
);
    import lpa_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [MAC_W-1:0]  mac_reg;
    logic [TIME_W-1:0] expiry_reg;
    lpa_carry_t        carry_reg;
    lpa_carry_t        carry_next;
    logic              live;

    // entry is live while its expiry is still ahead of the request time
    assign live = (expiry_reg > req_now);

    // fold this entry into the token: first live match, first free entry
    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && live && (mac_reg == req_mac))
        begin
            carry_next.hit     = 1'b1;
            carry_next.hit_idx = MY_IDX;
        end
        if (!carry_in.free && !live)
        begin
            carry_next.free     = 1'b1;
            carry_next.free_idx = MY_IDX;
        end
    end

    // token stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    // expiry starts at zero so every entry is free after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= '0;
        end
        else if (wr.en && (wr.idx == MY_IDX))
        begin
            expiry_reg <= wr.expiry;
        end
    end

    // address is only looked at while the entry is live
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == MY_IDX))
        begin
            mac_reg <= wr.mac;
        end
    end

    assign carry_out = carry_reg;

endmodule : lpa_cell

`default_nettype wire

### rtl/lease_pool_allocator.sv
// lease_pool_allocator: top level, request/result streams, config registers,
// controller and the row of lease cells; depends on lpa_pkg and lpa_cell
//
// Usage:
//   s_* carries one request per transfer: client address and current time.
//   m_* returns one result per request: host number and outcome code.
//   cfg_wen/cfg_index/cfg_data write pool_start (index 0) or lease_time (index 1);
//   write only while no request is in flight.
// Search and throughput:
//   a request launches a search token that steps through the row of
//   POOL_SIZE cells, one cell per cycle; when it leaves the last cell the
//   outcome is settled and then handed on to the output register.
//   One request is worked on at a time; the next request is taken as soon
//   as the result has moved to the output register.
// Reset:
//   rst_n clears all expiries (every entry free) and loads the register
//   defaults; no clearing pass is needed.
// Stall:
//   a result waits in the output register while m_tready is low; a second
//   finished result holds the controller until the first is taken.
`default_nettype none

module lease_pool_allocator #(
    parameter int unsigned POOL_SIZE = lpa_pkg::POOL_SIZE_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [47:0] mac_address, [79:48] now_seconds
    input  wire logic [lpa_pkg::IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] host_number, [9:8] outcome, [15:10] zero
    output logic [lpa_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                            cfg_wen,
    input  wire logic [lpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lpa_pkg::*;

    lpa_state_t            state_reg, state_next;
    logic                  start_reg, start_next;
    logic [MAC_W-1:0]      req_mac_reg;
    logic [TIME_W-1:0]     req_now_reg;
    logic [HOST_W-1:0]     pool_start_reg;
    logic [LEASE_W-1:0]    lease_time_reg;
    logic [HOST_W-1:0]     res_host_reg, res_host_next;
    lpa_outcome_t          res_outcome_reg, res_outcome_next;
    logic                  res_claim_reg, res_claim_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [TIME_W-1:0]     res_expiry_reg, res_expiry_next;
    logic                  out_valid_reg, out_valid_next;
    logic [HOST_W-1:0]     out_host_reg;
    lpa_outcome_t          out_outcome_reg;
    logic                  out_load;
    logic                  req_take;
    logic [TIME_W:0]       until_sum;
    lpa_write_t            wr;
    lpa_carry_t            chain [POOL_SIZE+1];
    lpa_carry_t            tail;
    logic [POOL_SIZE:0]    tok_vec;

    assign req_take = s_tvalid && s_tready;
    assign tail     = chain[POOL_SIZE];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= POOL_START_RST;
            lease_time_reg <= LEASE_TIME_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_POOL_START: pool_start_reg <= cfg_data[HOST_W-1:0];
                REG_LEASE_TIME: lease_time_reg <= cfg_data[LEASE_W-1:0];
                default:        ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_mac_reg <= s_tdata[MAC_W-1:0];
            req_now_reg <= s_tdata[MAC_W+TIME_W-1:MAC_W];
        end
    end

    // claimed expiry, saturated at the top of the time range
    assign until_sum = {1'b0, req_now_reg} + {{(TIME_W+1-LEASE_W){1'b0}}, lease_time_reg};

    // controller state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            res_claim_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            res_claim_reg <= res_claim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // decision and output payload
    always_ff @(posedge clk)
    begin
        res_host_reg    <= res_host_next;
        res_outcome_reg <= res_outcome_next;
        res_idx_reg     <= res_idx_next;
        res_expiry_reg  <= res_expiry_next;
        if (out_load)
        begin
            out_host_reg    <= res_host_reg;
            out_outcome_reg <= res_outcome_reg;
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        start_next       = 1'b0;
        res_host_next    = res_host_reg;
        res_outcome_next = res_outcome_reg;
        res_claim_next   = res_claim_reg;
        res_idx_next     = res_idx_reg;
        res_expiry_next  = res_expiry_reg;
        out_load         = 1'b0;
        s_tready         = 1'b0;
        wr               = '0;
        out_valid_next   = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    start_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // token leaves the last cell: settle the outcome
                if (tail.valid)
                begin
                    state_next      = ST_RESULT;
                    res_expiry_next = until_sum[TIME_W] ? {TIME_W{1'b1}}
                                                        : until_sum[TIME_W-1:0];
                    if (tail.hit)
                    begin
                        res_host_next    = pool_start_reg + tail.hit_idx;
                        res_outcome_next = OUT_REUSED;
                        res_claim_next   = 1'b0;
                        res_idx_next     = tail.hit_idx;
                    end
                    else if (tail.free)
                    begin
                        res_host_next    = pool_start_reg + tail.free_idx;
                        res_outcome_next = OUT_CLAIMED;
                        res_claim_next   = 1'b1;
                        res_idx_next     = tail.free_idx;
                    end
                    else
                    begin
                        res_host_next    = '0;
                        res_outcome_next = OUT_EXHAUSTED;
                        res_claim_next   = 1'b0;
                        res_idx_next     = '0;
                    end
                end
            end
            ST_RESULT:
            begin
                // hand over once the output register is free, commit the claim
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    wr.en          = res_claim_reg;
                    wr.idx         = res_idx_reg;
                    wr.mac         = req_mac_reg;
                    wr.expiry      = res_expiry_reg;
                    res_claim_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // token injection at the head of the row
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = start_reg;
    end

    // row of lease cells
    for (genvar k = 0; k < POOL_SIZE; k++)
    begin : g_cell
        lpa_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req_mac   (req_mac_reg),
            .req_now   (req_now_reg),
            .wr        (wr),
            .carry_in  (chain[k]),
            .carry_out (chain[k+1])
        );
    end

    // token positions along the row
    for (genvar k = 0; k <= POOL_SIZE; k++)
    begin : g_tok
        assign tok_vec[k] = chain[k].valid;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-HOST_W-OUTCOME_W){1'b0}}, out_outcome_reg, out_host_reg};

`ifndef NO_ASSERTIONS
    // only one search token is ever in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the cell row");

    // the token reaches the end of the row only while scanning
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == ST_SCAN)
        else $error("search token finished outside the scan state");

    // a taken request launches exactly one token next cycle
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> start_reg && state_reg == ST_SCAN)
        else $error("request taken without launching a search");

    // an entry is claimed only inside the pool and only as a result is handed over
    a_claim_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (wr.idx < IDX_W'(POOL_SIZE)) && out_load
                  && res_outcome_reg == OUT_CLAIMED)
        else $error("entry write outside the pool or without a claim result");

    // a result never carries the unused outcome code
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_outcome_reg == OUT_REUSED || out_outcome_reg == OUT_CLAIMED
                      || out_outcome_reg == OUT_EXHAUSTED))
        else $error("result with an undefined outcome code");
`endif

endmodule : lease_pool_allocator

`default_nettype wire
